// File: hw/rtl/gcbd_pkg.sv
// Package with the shared types, constants and divider step functions of the grid cell block.
`default_nettype none
package gcbd_pkg;

   localparam int MAX_CELLS  = 1024;
   localparam int CNT_W      = 11;
   localparam int SIZE_W     = 31;
   localparam int POS_W      = 32;
   localparam int IDX_W      = 12;
   localparam int Q_W        = 32;
   localparam int DIV_STAGES = Q_W;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;
   localparam int REQ_W      = 232;
   localparam int RSP_W      = 72;

   localparam logic [CNT_W-1:0] CELLS_RESET = CNT_W'(1024);
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(65536);
   localparam logic [31:0] DIST_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] DIST_MIN = 32'h8000_0000;

   typedef enum logic {
      CSR_CELLS = 1'b0,
      CSR_SIZE  = 1'b1
   } csr_index_type;

   // Classified axis: operands for the divider and the candidate next index.
   typedef struct packed {
      logic             ahead;
      logic             neg;
      logic             sat;
      logic [Q_W-1:0]   num;
      logic [Q_W-1:0]   den;
      logic [IDX_W-1:0] nxt;
   } axis_type;

   typedef struct packed {
      axis_type [2:0]              ax;
      logic     [2:0][IDX_W-1:0]   idx;
   } entry_type;

   // One axis in flight through the divider.
   typedef struct packed {
      logic             ahead;
      logic             neg;
      logic             sat;
      logic [Q_W-1:0]   rem;
      logic [Q_W-1:0]   nb;
      logic [Q_W-1:0]   q;
      logic [Q_W-1:0]   den;
      logic [IDX_W-1:0] nxt;
   } div_type;

   // The dividend is num * 2^30; its top bits seed the remainder.
   function automatic div_type div_init(axis_type a);
      div_type r;
      r.ahead = a.ahead;
      r.neg   = a.neg;
      r.sat   = a.sat;
      r.rem   = {2'b00, a.num[Q_W-1:2]};
      r.nb    = {a.num[1:0], 30'b0};
      r.q     = '0;
      r.den   = a.den;
      r.nxt   = a.nxt;
      return r;
   endfunction

   // One restoring division step: one quotient bit.
   function automatic div_type div_step(div_type d);
      logic [Q_W:0] t;
      logic [Q_W:0] diff;
      div_type      r;
      r    = d;
      t    = {d.rem, d.nb[Q_W-1]};
      diff = t - {1'b0, d.den};
      if (!diff[Q_W]) begin
         r.rem = diff[Q_W-1:0];
         r.q   = {d.q[Q_W-2:0], 1'b1};
      end else begin
         r.rem = t[Q_W-1:0];
         r.q   = {d.q[Q_W-2:0], 1'b0};
      end
      r.nb = {d.nb[Q_W-2:0], 1'b0};
      return r;
   endfunction

   // Apply the sign and saturate to the signed 32-bit range.
   function automatic logic [31:0] div_result(div_type d);
      logic [32:0] mag;
      logic [31:0] r;
      mag = d.sat ? 33'h1_0000_0000 : {1'b0, d.q};
      if (d.neg) begin
         if (mag >= 33'h0_8000_0000) r = DIST_MIN;
         else r = 32'(-mag);
      end else begin
         if (mag > 33'h0_7FFF_FFFF) r = DIST_MAX;
         else r = mag[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/gcbd_front.sv
// Front end: accepts queries, works out the face ahead on each axis and the divider operands.
`default_nettype none
module gcbd_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [gcbd_pkg::REQ_W-1:0]   req_data,
   input  wire logic [gcbd_pkg::CNT_W-1:0]   cells,
   input  wire logic [gcbd_pkg::SIZE_W-1:0]  cell_size,
   input  wire logic                         q_full,
   output logic                              q_push,
   output gcbd_pkg::entry_type               q_data
);

   logic                                   en;
   logic                                   s1_valid_ff, s2_valid_ff;
   logic signed [44:0]                     s1_face_ff [3];
   logic signed [44:0]                     s1_face_in [3];
   logic        [31:0]                     s1_pos_ff  [3];
   logic        [31:0]                     s1_dir_ff  [3];
   logic        [gcbd_pkg::IDX_W-1:0]      s1_nxt_ff  [3];
   logic        [gcbd_pkg::IDX_W-1:0]      s1_nxt_in  [3];
   logic        [2:0]                      s1_ahead_ff, s1_ahead_in;
   logic        [2:0][gcbd_pkg::IDX_W-1:0] s1_idx_ff;
   gcbd_pkg::entry_type                    s2_ff, s2_in;
   logic        [gcbd_pkg::CNT_W-1:0]      count;

   // The whole front advances unless its last stage cannot enter the queue.
   assign en        = !(s2_valid_ff && q_full);
   assign req_ready = en;
   assign q_push    = s2_valid_ff && !q_full;
   assign q_data    = s2_ff;

   assign count = (cells > gcbd_pkg::CNT_W'(gcbd_pkg::MAX_CELLS)) ?
                  gcbd_pkg::CNT_W'(gcbd_pkg::MAX_CELLS) : cells;

   // Face test and face position on each axis.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         logic signed [31:0]                dir;
         logic signed [gcbd_pkg::IDX_W-1:0] idx;
         logic signed [12:0]                fidx;
         logic signed [44:0]                fi;
         logic signed [44:0]                sz;
         dir  = $signed(req_data[96 + 32*a +: 32]);
         idx  = $signed(req_data[192 + 12*a +: 12]);
         fidx = 13'(idx);
         s1_ahead_in[a] = 1'b0;
         s1_nxt_in[a]   = idx;
         if (dir > 0) begin
            fidx = 13'(idx) + 13'sd1;
            s1_nxt_in[a]   = gcbd_pkg::IDX_W'(idx + 12'sd1);
            s1_ahead_in[a] = idx < $signed({1'b0, count});
         end else if (dir < 0) begin
            s1_nxt_in[a]   = gcbd_pkg::IDX_W'(idx - 12'sd1);
            s1_ahead_in[a] = !idx[gcbd_pkg::IDX_W-1];
         end
         fi = 45'(fidx);
         sz = 45'($signed({1'b0, cell_size}));
         s1_face_in[a] = fi * sz;
      end
   end

   // Distance to the face, its magnitude and the saturation test.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         logic signed [45:0] diff;
         logic        [45:0] mag;
         logic        [32:0] den;
         logic signed [31:0] dir;
         dir  = $signed(s1_dir_ff[a]);
         diff = 46'(s1_face_ff[a]) - 46'($signed(s1_pos_ff[a]));
         mag  = diff[45] ? 46'(-diff) : 46'(diff);
         den  = dir[31] ? 33'(-33'(dir)) : 33'(dir);
         s2_in.ax[a].ahead = s1_ahead_ff[a];
         s2_in.ax[a].neg   = diff[45] ^ dir[31];
         s2_in.ax[a].sat   = mag >= {12'b0, den, 1'b0};
         s2_in.ax[a].num   = mag[31:0];
         s2_in.ax[a].den   = den[31:0];
         s2_in.ax[a].nxt   = s1_nxt_ff[a];
      end
      s2_in.idx = s1_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < 3; a++) begin
            s1_face_ff[a] <= s1_face_in[a];
            s1_pos_ff[a]  <= req_data[32*a +: 32];
            s1_dir_ff[a]  <= req_data[96 + 32*a +: 32];
            s1_nxt_ff[a]  <= s1_nxt_in[a];
            s1_idx_ff[a]  <= req_data[192 + 12*a +: 12];
         end
         s1_ahead_ff <= s1_ahead_in;
         s2_ff       <= s2_in;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/gcbd_queue.sv
// Short queue between the front end and the divider back end.
`default_nettype none
module gcbd_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire gcbd_pkg::entry_type  push_data,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      empty,
   output gcbd_pkg::entry_type       pop_data
);

   gcbd_pkg::entry_type               mem_ff [gcbd_pkg::FIFO_DEPTH];
   logic [gcbd_pkg::FIFO_AW-1:0]      wptr_ff, rptr_ff;
   logic [gcbd_pkg::FIFO_AW:0]        cnt_ff;

   assign full     = cnt_ff == (gcbd_pkg::FIFO_AW+1)'(gcbd_pkg::FIFO_DEPTH);
   assign empty    = cnt_ff == '0;
   assign pop_data = mem_ff[rptr_ff];

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (push) wptr_ff <= wptr_ff + 1'b1;
         if (pop)  rptr_ff <= rptr_ff + 1'b1;
         if (push && !pop) cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= push_data;
   end

endmodule
`default_nettype wire

// File: hw/rtl/gcbd_back.sv
// Back end: three pipelined dividers, nearest-face selection and the result register.
`default_nettype none
module gcbd_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         q_empty,
   input  wire gcbd_pkg::entry_type          q_data,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [gcbd_pkg::RSP_W-1:0]        rsp_data
);

   localparam int NS = gcbd_pkg::DIV_STAGES;

   logic                                   en;
   logic [NS:0]                            valid_ff;
   gcbd_pkg::div_type                      div_ff [NS+1][3];
   logic [2:0][gcbd_pkg::IDX_W-1:0]        idx_ff [NS+1];
   logic                                   rsp_valid_ff;
   logic [gcbd_pkg::RSP_W-1:0]             rsp_data_ff, rsp_data_in;

   // The back end moves as one whenever the result register is free.
   assign en        = !rsp_valid_ff || rsp_ready;
   assign q_pop     = en && !q_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff     <= {valid_ff[NS-1:0], !q_empty};
         rsp_valid_ff <= valid_ff[NS];
      end
   end

   // Divider stages: one quotient bit per stage on every axis.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < 3; a++) begin
            div_ff[0][a] <= gcbd_pkg::div_init(q_data.ax[a]);
            for (int s = 0; s < NS; s++) begin
               div_ff[s+1][a] <= gcbd_pkg::div_step(div_ff[s][a]);
            end
         end
         idx_ff[0] <= q_data.idx;
         for (int s = 0; s < NS; s++) begin
            idx_ff[s+1] <= idx_ff[s];
         end
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Pick the nearest face; ties go to x, then y.
   always_comb begin
      logic signed [31:0]                best;
      logic signed [31:0]                d;
      logic [2:0][gcbd_pkg::IDX_W-1:0]   nxt;
      best = $signed(gcbd_pkg::DIST_MAX);
      nxt  = idx_ff[NS];
      for (int a = 0; a < 3; a++) begin
         d = $signed(gcbd_pkg::div_result(div_ff[NS][a]));
         if (div_ff[NS][a].ahead && ((a == 0) ? (d <= best) : (d < best))) begin
            best   = d;
            nxt    = idx_ff[NS];
            nxt[a] = div_ff[NS][a].nxt;
         end
      end
      rsp_data_in = {4'b0, nxt[2], nxt[1], nxt[0], best};
   end

endmodule
`default_nettype wire

// File: hw/rtl/grid_cell_boundary_distance_top.sv
// Top level of the grid cell boundary distance block.
//
//  channel  direction  handshake            contents
//  req      in         req_tvalid/tready    position, direction, current cell
//  rsp      out        rsp_tvalid/tready    distance, next cell
//  csr      in         csr_we               cells_per_axis, cell_size
//
// One query is accepted and one result leaves per cycle when nothing stalls.
// Without stalls a query passes two front stages, one queue slot,
// 33 divider stages (an operand stage, then one quotient bit each) and the
// result register.
// Reset clears all valid bits and sets the CSRs to their reset values.
// A stalled result holds the back end; the front end keeps accepting
// until the four-entry queue is full.
`default_nettype none
module grid_cell_boundary_distance_top (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, cell_i, cell_j, cell_k, zero pad
   input  wire logic [231:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // distance, next_i, next_j, next_k, zero pad
   output logic [71:0]       rsp_tdata,
   input  wire logic         csr_we,
   input  wire logic         csr_index,
   input  wire logic [30:0]  csr_wdata
);

   logic [gcbd_pkg::CNT_W-1:0]  cells_ff;
   logic [gcbd_pkg::SIZE_W-1:0] size_ff;
   logic                        q_push, q_full, q_pop, q_empty;
   gcbd_pkg::entry_type         q_in, q_out;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cells_ff <= gcbd_pkg::CELLS_RESET;
         size_ff  <= gcbd_pkg::SIZE_RESET;
      end else if (csr_we) begin
         unique case (gcbd_pkg::csr_index_type'(csr_index))
            gcbd_pkg::CSR_CELLS: cells_ff <= csr_wdata[gcbd_pkg::CNT_W-1:0];
            gcbd_pkg::CSR_SIZE:  size_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   gcbd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_data  (req_tdata),
      .cells     (cells_ff),
      .cell_size (size_ff),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_in)
   );

   gcbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_out)
   );

   gcbd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_out),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_tdata)
   );

endmodule
`default_nettype wire

// File: hw/rtl/gcbd_checker.sv
// Port-level checker for the grid cell boundary distance block, with its bind.
`default_nettype none
module gcbd_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [71:0]  rsp_tdata
);

   // A stalled result stays valid and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Reset leaves no result pending.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Input back-pressure only follows a stalled result.
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> $past(rsp_tvalid && !rsp_tready))
      else $error("input stalled without output back-pressure");

   // The zero pad of the result stays clear.
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[71:68] == 4'b0)
      else $error("result pad bits set");

endmodule

bind grid_cell_boundary_distance_top gcbd_checker u_gcbd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
